// ===== hdl/csrmv_pkg.sv =====
// Shared types and constants for the CSR sparse matrix-vector multiplier.
// Holds the request and result structs, the function codes and the command
// and status structs between controller and datapath. No dependencies.
package csrmv_pkg;

	localparam int MAX_COLS = 1024;
	localparam int MAX_ROWS = 1024;
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int DATA_W   = 32;

	typedef enum logic [1:0] {
		FUNC_START = 2'd0,
		FUNC_VEC   = 2'd1,
		FUNC_MAT   = 2'd2,
		FUNC_EMPTY = 2'd3
	} func_t;

	typedef struct packed {
		func_t              func;
		logic [9:0]         index;
		logic signed [31:0] value;
		logic               row_end;
	} in_item_t;

	typedef struct packed {
		logic [9:0]         row_index;
		logic signed [31:0] sum;
		logic [9:0]         position;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_item;
		logic vec_write;
		logic clear_regs;
		logic clear_step;
		logic mul_en;
		logic acc_en;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_done;
		logic acc_nz;
		logic out_busy;
		logic row_end;
	} sts_t;

endpackage

// ===== hdl/csrmv_ctrl.sv =====
// Controller state machine of the CSR sparse matrix-vector multiplier.
// Sequences the clearing pass, vector writes, the lookup, multiply, accumulate and row end.
// Depends on csrmv_pkg.
module csrmv_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  csrmv_pkg::func_t func,
	input  csrmv_pkg::sts_t  sts,
	output logic             item_stall,
	output csrmv_pkg::cmd_t  cmd
);
	import csrmv_pkg::*;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_READ  = 6'b000100,
		ST_MUL   = 6'b001000,
		ST_ACC   = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					cmd.load_item = 1'b1;
					case (func)
						FUNC_START: begin
							cmd.clear_regs = 1'b1;
							state_d        = ST_CLEAR;
						end
						FUNC_VEC: begin
							cmd.vec_write = 1'b1;
						end
						FUNC_MAT: begin
							state_d = ST_READ;
						end
						default: begin
							state_d = ST_FIN;
						end
					endcase
				end
			end
			ST_READ: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_en = 1'b1;
				state_d    = sts.row_end ? ST_FIN : ST_IDLE;
			end
			ST_FIN: begin
				// A nonzero sum waits until the result register is free.
				if (!(sts.acc_nz && sts.out_busy)) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	a_no_finish_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !(sts.acc_nz && sts.out_busy))
		else $error("row finished while result register was held");

	a_clear_until_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) && !sts.clr_done |=> (state_q == ST_CLEAR))
		else $error("clearing pass left early");

	a_mat_path: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_en |=> cmd.acc_en)
		else $error("product not accumulated after multiply");

endmodule

// ===== hdl/csrmv_dp.sv =====
// Datapath of the CSR sparse matrix-vector multiplier: vector memory with
// valid flags, multiplier, row accumulator, counters and result register.
// Depends on csrmv_pkg.
module csrmv_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  csrmv_pkg::in_item_t item,
	input  csrmv_pkg::cmd_t     cmd,
	input  logic                result_stall,
	output csrmv_pkg::sts_t     sts,
	output logic                result_valid,
	output csrmv_pkg::out_item_t result
);
	import csrmv_pkg::*;

	// Each word holds a valid flag above the 32-bit vector value.
	logic [DATA_W:0]   mem [MAX_COLS];
	logic [DATA_W:0]   rd_q;
	in_item_t          item_q;
	logic [COL_W-1:0]  clr_addr_q;
	logic [DATA_W-1:0] prod_q;
	logic [DATA_W-1:0] mul_lo;
	logic [DATA_W-1:0] acc_q;
	logic [ROW_W-1:0]  row_q;
	logic [ROW_W-1:0]  count_q;
	logic              out_valid_q;
	out_item_t         out_q;

	always_ff @(posedge clk) begin
		if (cmd.clear_step) begin
			mem[clr_addr_q] <= '0;
		end else if (cmd.vec_write) begin
			mem[item.index[COL_W-1:0]] <= {1'b1, item.value};
		end
		rd_q <= mem[item_q.index[COL_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= item;
		end
		if (cmd.mul_en) begin
			prod_q <= rd_q[DATA_W] ? mul_lo : '0;
		end
		if (cmd.finish && (acc_q != '0)) begin
			out_q.row_index <= row_q;
			out_q.sum       <= acc_q;
			out_q.position  <= count_q;
		end
	end

	// Only the low word of the product is kept, so signedness does not matter.
	assign mul_lo = DATA_W'($unsigned(item_q.value) * rd_q[DATA_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			acc_q       <= '0;
			row_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_step) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (cmd.clear_regs) begin
				acc_q   <= '0;
				row_q   <= '0;
				count_q <= '0;
			end else if (cmd.acc_en) begin
				acc_q <= acc_q + prod_q;
			end else if (cmd.finish) begin
				acc_q <= '0;
				row_q <= row_q + 1'b1;
				if (acc_q != '0) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (cmd.finish && (acc_q != '0)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.clr_done = (clr_addr_q == {COL_W{1'b1}});
	assign sts.acc_nz   = (acc_q != '0);
	assign sts.out_busy = out_valid_q && result_stall;
	assign sts.row_end  = item_q.row_end;

	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_nonzero_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.sum != '0))
		else $error("result presented with a zero sum");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_regs |=> (acc_q == '0) && (count_q == '0) && (row_q == '0))
		else $error("start did not clear row state");

	a_no_write_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clear_step && cmd.vec_write))
		else $error("vector write during clearing pass");

endmodule

// ===== hdl/csr_sparse_matrix_vector_multiply.sv =====
// Top level of the CSR sparse matrix-vector multiplier.
// Joins the controller and the datapath. Depends on csrmv_pkg, csrmv_ctrl
// and csrmv_dp.
//
// Usage. Requests arrive on item (item_valid, item_stall) and carry a
// function code: start, vector entry, matrix nonzero or empty matrix row.
// A request is taken at a rising edge with item_valid high and item_stall
// low. Results leave on result (result_valid, result_stall) and carry the
// row index, the wrapped 32-bit row sum and the slot in the result list.
// Only rows whose sum is nonzero produce a result.
//
// Sequence. A vector entry request is written as it is taken, and the
// block stays ready. A matrix nonzero is followed by a registered read of
// the 1024-entry vector memory, a registered 32x32 multiply and the
// accumulate; its row end flag, or an empty row request, then closes the
// row. The result appears in the cycle after the row is closed.
//
// Reset and start. After reset, and after every start request, the block
// runs a clearing pass over the 1024-entry vector memory, one entry a
// cycle, during which item_stall stays high. The memory has a single
// write port, so this pass sets the cost of a start request.
//
// Stalls. The result register holds its contents while result_stall is
// high. The block keeps taking requests meanwhile; only closing a row with
// a nonzero sum waits until the waiting result has been taken.
module csr_sparse_matrix_vector_multiply (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  csrmv_pkg::in_item_t   item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output csrmv_pkg::out_item_t  result
);
	import csrmv_pkg::*;

	cmd_t cmd;
	sts_t sts;

	csrmv_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.func       (item.func),
		.sts        (sts),
		.item_stall (item_stall),
		.cmd        (cmd)
	);

	csrmv_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.result_stall (result_stall),
		.sts          (sts),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

// ===== tb/sv/tb_csr_sparse_matrix_vector_multiply.sv =====
// Self-checking testbench for the CSR sparse matrix-vector multiplier.
// Drives request streams of vector entries and matrix rows and checks every
// result against an in-bench shadow. Depends on csrmv_pkg and the top level.
module tb_csr_sparse_matrix_vector_multiply;
	import csrmv_pkg::*;

	// A start request costs a clearing pass of the vector memory with the
	// input stalled, and the pressure test holds the result side for
	// HOLD_CYCLES, so the quiet-cycle limit sits well above both.
	localparam int unsigned QUIET_LIMIT = 6000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int unsigned REPORT_MAX = 10;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_stall;
	in_item_t   item = '0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	out_item_t  result;

	csr_sparse_matrix_vector_multiply dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #10 clk = ~clk;

	// Shadow copy of the block's state, updated on every accepted request.
	logic [31:0] shadow_vec   [MAX_COLS];
	bit          shadow_valid [MAX_COLS];
	logic [9:0]  shadow_row  = '0;
	logic [31:0] shadow_acc  = '0;
	logic [9:0]  shadow_slot = '0;
	out_item_t   expected_rows [$];

	// Stimulus-side bookkeeping. A column is only ever read by a matrix
	// request once it has been written at least once since reset; live
	// columns are those written since the last start.
	bit          seen_col [MAX_COLS];
	logic [9:0]  seen_list [$];
	logic [9:0]  live_list [$];

	// Idling controls for each side, and a request for a long result hold.
	bit          tx_idle = 1'b1;
	bit          rx_idle = 1'b1;
	int unsigned hold_cycles = 0;
	int unsigned fail_count = 0;

	// Closing a row emits its sum only when nonzero, but the row counter
	// always advances. Both counters wrap at ten bits, as MAX_ROWS is 1024.
	function automatic void close_row();
		if (shadow_acc != 32'd0) begin
			expected_rows.push_back(out_item_t'{row_index: shadow_row,
				sum: shadow_acc, position: shadow_slot});
			shadow_slot = shadow_slot + 10'd1;
		end
		shadow_row = shadow_row + 10'd1;
		shadow_acc = '0;
	endfunction

	function automatic void update_row_product(in_item_t req);
		logic [31:0] operand;
		case (req.func)
			FUNC_START: begin
				shadow_valid = '{default: 1'b0};
				shadow_row = '0;
				shadow_acc = '0;
				shadow_slot = '0;
			end
			FUNC_VEC: begin
				shadow_vec[req.index] = req.value;
				shadow_valid[req.index] = 1'b1;
			end
			FUNC_MAT: begin
				// A column not written since the last start reads as zero.
				operand = shadow_valid[req.index] ? shadow_vec[req.index] : 32'd0;
				// Only the low 32 bits of the product count, and the sum wraps.
				shadow_acc = shadow_acc + req.value * operand;
				if (req.row_end) begin
					close_row();
				end
			end
			FUNC_EMPTY: begin
				// An empty row closes whatever the accumulator holds.
				close_row();
			end
		endcase
	endfunction

	// Values lean towards the extremes and towards small numbers so that
	// wrapping products and exact sums both turn up.
	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'hFFFF_FFFF;
			3: return 32'h7FFF_FFFF;
			4: return 32'h8000_0000;
			5, 6: return 32'($signed($urandom_range(0, 64)) - 32);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [9:0] pick_column();
		if (live_list.size() != 0 && $urandom_range(0, 4) != 0) begin
			return live_list[$urandom_range(0, live_list.size() - 1)];
		end
		return seen_list[$urandom_range(0, seen_list.size() - 1)];
	endfunction

	// Sends one request: an optional idle gap, then valid held with a steady
	// payload until an edge at which the block does not stall. The task
	// returns just after the accepting edge.
	task automatic send_request(func_t f, logic [9:0] idx, logic [31:0] val,
			logic last);
		in_item_t    req;
		int unsigned gap;
		req.func = f;
		req.index = idx;
		req.value = val;
		req.row_end = last;
		if (f == FUNC_START) begin
			live_list.delete();
		end
		if (f == FUNC_VEC) begin
			live_list.push_back(idx);
			if (!seen_col[idx]) begin
				seen_col[idx] = 1'b1;
				seen_list.push_back(idx);
			end
		end
		gap = tx_idle ? $urandom_range(0, 5) : 0;
		repeat (gap) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= req;
		do @(posedge clk); while (item_stall);
	endtask

	// Extremes of every field, each function code, row_end on requests that
	// ignore it, wrapping products, a zero row, an empty row both after a
	// proper row end and in the middle of a row, and a column that was
	// written before a start and so reads as zero afterwards.
	task automatic test_directed_cases();
		send_request(FUNC_START, 10'd1023, 32'hFFFF_FFFF, 1'b1);
		send_request(FUNC_VEC, 10'd0, 32'h7FFF_FFFF, 1'b1);
		send_request(FUNC_VEC, 10'd1023, 32'h8000_0000, 1'b0);
		send_request(FUNC_VEC, 10'd5, 32'hFFFF_FFFF, 1'b0);
		send_request(FUNC_VEC, 10'd5, 32'd3, 1'b0);
		send_request(FUNC_MAT, 10'd0, 32'h7FFF_FFFF, 1'b0);
		send_request(FUNC_MAT, 10'd1023, 32'h8000_0000, 1'b0);
		send_request(FUNC_MAT, 10'd5, 32'hFFFF_FFFF, 1'b1);
		send_request(FUNC_EMPTY, 10'd1023, 32'hFFFF_FFFF, 1'b1);
		send_request(FUNC_MAT, 10'd0, 32'd0, 1'b1);
		send_request(FUNC_MAT, 10'd5, 32'd2, 1'b0);
		send_request(FUNC_EMPTY, 10'd0, 32'd0, 1'b0);
		send_request(FUNC_MAT, 10'd1023, 32'd1, 1'b1);
		send_request(FUNC_MAT, 10'd0, 32'd1, 1'b1);
		send_request(FUNC_MAT, 10'd5, 32'h8000_0000, 1'b0);
		send_request(FUNC_MAT, 10'd5, 32'h8000_0000, 1'b1);
		send_request(FUNC_START, 10'd0, 32'd0, 1'b0);
		send_request(FUNC_MAT, 10'd5, 32'd7, 1'b1);
		send_request(FUNC_VEC, 10'd5, 32'd9, 1'b1);
		send_request(FUNC_MAT, 10'd5, 32'hFFFF_FFFD, 1'b1);
		send_request(FUNC_MAT, 10'd1023, 32'd4, 1'b1);
	endtask

	// The result side is held off for a long stretch while single-element
	// rows with odd products, which are never zero, keep arriving, so the
	// block must stall its input once it cannot close another row.
	task automatic test_result_backpressure();
		logic [9:0] col;
		tx_idle = 1'b0;
		col = 10'($urandom_range(0, 1023));
		send_request(FUNC_VEC, col, $urandom | 32'd1, 1'b0);
		hold_cycles = HOLD_CYCLES;
		repeat (40) begin
			send_request(FUNC_MAT, col, $urandom | 32'd1, 1'b1);
		end
	endtask

	// Well-formed phases of random content: an occasional start, a batch of
	// vector entries, then rows of zero to five nonzeros. About one request
	// in ten inside a row is noise that may cut the row short.
	task automatic test_random_rows(int unsigned n_items);
		int unsigned sent;
		int unsigned rows;
		int unsigned nnz;
		sent = 0;
		while (sent < n_items) begin
			tx_idle = $urandom_range(0, 3) != 0;
			rx_idle = $urandom_range(0, 3) != 0;
			if ($urandom_range(0, 3) == 0) begin
				send_request(FUNC_START, 10'($urandom_range(0, 1023)), $urandom,
					1'($urandom_range(0, 1)));
				sent++;
			end
			repeat ($urandom_range(1, 12)) begin
				send_request(FUNC_VEC, 10'($urandom_range(0, 1023)), rand_value(),
					1'($urandom_range(0, 1)));
				sent++;
			end
			rows = $urandom_range(1, 8);
			repeat (rows) begin
				nnz = $urandom_range(0, 5);
				if (nnz == 0) begin
					send_request(FUNC_EMPTY, 10'($urandom_range(0, 1023)), $urandom,
						1'($urandom_range(0, 1)));
					sent++;
				end
				for (int j = 0; j < nnz; j++) begin
					if ($urandom_range(0, 9) == 0) begin
						send_request($urandom_range(0, 1) ? FUNC_VEC : FUNC_EMPTY,
							10'($urandom_range(0, 1023)), rand_value(),
							1'($urandom_range(0, 1)));
						sent++;
					end
					send_request(FUNC_MAT, pick_column(), rand_value(), j == nnz - 1);
					sent++;
				end
			end
		end
	endtask

	// Enough rows after one start to wrap both the row counter and the
	// result slot. Odd vector entries times odd matrix values are never zero,
	// so every single-element row is known to produce a result.
	task automatic test_counter_wrap();
		logic [9:0]  cols [$];
		logic [9:0]  col;
		int unsigned odd_rows;
		send_request(FUNC_START, 10'($urandom_range(0, 1023)), $urandom,
			1'($urandom_range(0, 1)));
		repeat (6) begin
			col = 10'($urandom_range(0, 1023));
			cols.push_back(col);
			send_request(FUNC_VEC, col, $urandom | 32'd1, 1'($urandom_range(0, 1)));
		end
		odd_rows = 0;
		while (odd_rows < 1040) begin
			if (odd_rows % 100 == 0) begin
				tx_idle = $urandom_range(0, 2) != 0;
				rx_idle = $urandom_range(0, 2) != 0;
			end
			if ($urandom_range(0, 19) == 0) begin
				send_request(FUNC_EMPTY, 10'($urandom_range(0, 1023)), $urandom,
					1'($urandom_range(0, 1)));
			end else begin
				send_request(FUNC_MAT, cols[$urandom_range(0, cols.size() - 1)],
					$urandom | 32'd1, 1'b1);
				odd_rows++;
			end
		end
	endtask

	// Result side. Before each result it may stall for a random pause when rx_idle
	// is set, and on request it holds stall high for a long stretch of its own counting.
	initial begin : result_sink
		int unsigned pause;
		forever begin
			if (hold_cycles != 0) begin
				result_stall <= 1'b1;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			pause = rx_idle ? $urandom_range(0, 5) : 0;
			repeat (pause) begin
				result_stall <= 1'b1;
				@(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid && hold_cycles == 0);
		end
	end

	// Both handshakes are sampled at the rising edge, before any of this
	// edge's nonblocking updates land, so requests and results are seen
	// exactly as the block sees them.
	always @(posedge clk) begin : scoreboard
		out_item_t want;
		if (item_valid && !item_stall) begin
			update_row_product(item);
		end
		if (arst_n && result_valid && !result_stall) begin
			if (expected_rows.size() == 0) begin
				if (fail_count < REPORT_MAX) begin
					$display("unexpected result: row %0d sum %0d slot %0d",
						result.row_index, result.sum, result.position);
				end
				fail_count++;
			end else begin
				want = expected_rows.pop_front();
				if (result.row_index !== want.row_index || result.sum !== want.sum ||
						result.position !== want.position) begin
					if (fail_count < REPORT_MAX) begin
						$display(
							"mismatch: want row %0d sum %0d slot %0d, got row %0d sum %0d slot %0d",
							want.row_index, want.sum, want.position,
							result.row_index, result.sum, result.position);
					end
					fail_count++;
				end
			end
		end
	end

	// Ends the run if neither side moves a request for too long.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("tb_csr_sparse_matrix_vector_multiply: done, errors");
		$finish;
	end

	initial begin : sequencer
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_result_backpressure();
		test_random_rows(60);
		test_counter_wrap();
		item_valid <= 1'b0;
		// Let the last request through the pipeline before judging the queue.
		repeat (8) @(posedge clk);
		while (expected_rows.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb_csr_sparse_matrix_vector_multiply: done, clean");
		end else begin
			$display("tb_csr_sparse_matrix_vector_multiply: done, errors");
		end
		$finish;
	end

endmodule
